// ===== hdl/gpiopr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO port register package
// Shared types and codes for the port, direction and pin register file.
// ----------------------------------------------------------------------------
package gpiopr_pkg;

   // Operation codes carried on the request channel.
   localparam logic [3:0] OP_CPU_WRITE   = 4'd0;
   localparam logic [3:0] OP_CPU_SET     = 4'd1;
   localparam logic [3:0] OP_CPU_CLEAR   = 4'd2;
   localparam logic [3:0] OP_CPU_READ    = 4'd3;
   localparam logic [3:0] OP_CPU_RDBIT   = 4'd4;
   localparam logic [3:0] OP_EXT_WRITE   = 4'd5;
   localparam logic [3:0] OP_EXT_SET     = 4'd6;
   localparam logic [3:0] OP_EXT_CLEAR   = 4'd7;
   localparam logic [3:0] OP_ANA_SET     = 4'd8;
   localparam logic [3:0] OP_ANA_READ    = 4'd9;

   // Event kinds.
   localparam logic [1:0] EV_NONE        = 2'd0;
   localparam logic [1:0] EV_PORT        = 2'd1;
   localparam logic [1:0] EV_DIR         = 2'd2;
   localparam logic [1:0] EV_ANALOG      = 2'd3;

   // Warning codes.
   localparam logic [2:0] WARN_NONE      = 3'd0;
   localparam logic [2:0] WARN_BLOCKED   = 3'd1;
   localparam logic [2:0] WARN_PIN_WRITE = 3'd2;
   localparam logic [2:0] WARN_EXT_DIR   = 3'd3;
   localparam logic [2:0] WARN_BAD_ADDR  = 3'd4;

   // Fixed register addresses and the serial echo port.
   localparam logic [7:0] STATUS_ADDR      = 8'd36;
   localparam logic [7:0] SERIAL_DATA_ADDR = 8'd37;
   localparam logic [3:0] SERIAL_ECHO_PORT = 4'd6;   // port G
   localparam logic [7:0] ALL_ONES_BYTE    = 8'hFF;
   localparam logic [7:0] ALL_ZERO_BYTE    = 8'h00;

   typedef struct packed {
      logic [3:0] op;
      logic [7:0] reg_addr;
      logic [2:0] bit_index;
      logic [7:0] data_byte;
      logic [3:0] port_index;
      logic [3:0] analog_channel;
      logic [9:0] analog_value;
   } req_type;

   typedef struct packed {
      logic [9:0] read_value;
      logic [1:0] event_kind;
      logic [3:0] event_index;
      logic [9:0] event_value;
      logic [2:0] warning;
   } rsp_type;

   // Store updates produced by one word.
   typedef struct packed {
      logic       reg_en;
      logic [7:0] reg_addr;
      logic [7:0] reg_data;
      logic       ana_en;
      logic [3:0] ana_channel;
      logic [9:0] ana_data;
   } upd_type;

endpackage : gpiopr_pkg
`default_nettype wire

// ===== hdl/gpio_port_register_model_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO port register model unit
// Port, direction and pin banks in a general byte store, plus analog levels.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake           | Contents
//   req_    | in        | req_valid/req_stall | op, address, bit, byte, port, channel
//   rsp_    | out       | rsp_valid/rsp_stall | read value, event, warning
//
// The accepting edge reads the byte store at two addresses (the addressed byte
// and its direction byte) into the fetch stage, where the word is decoded; when
// the fetch stage advances, the store and analog levels are written and the
// result is registered. A new word is accepted every cycle while req_stall is
// low. A write that lands on the same edge as the next word's read is forwarded
// into that word's fetched data.
// Reset is synchronous and clears all store entries through per-entry valid
// bits, so no clearing pass is needed; an entry that was never written reads
// as zero. When the result register is full and stalled, the word in the
// fetch stage holds and req_stall rises.
//
module gpio_port_register_model_unit #(
   parameter int NUM_PORTS  = 11,
   parameter int NUM_REGS   = 255,
   parameter int NUM_ANALOG = 16
) (
   input  logic       clock,
   input  logic       reset,
   // Request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [3:0] req_op,
   input  logic [7:0] req_reg_addr,
   input  logic [2:0] req_bit_index,
   input  logic [7:0] req_data_byte,
   input  logic [3:0] req_port_index,
   input  logic [3:0] req_analog_channel,
   input  logic [9:0] req_analog_value,
   // Result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [9:0] rsp_read_value,
   output logic [1:0] rsp_event_kind,
   output logic [3:0] rsp_event_index,
   output logic [9:0] rsp_event_value,
   output logic [2:0] rsp_warning
);
   import gpiopr_pkg::*;

   localparam int AW    = $clog2(NUM_REGS);
   localparam int DEPTH = 2 ** AW;
   localparam int AIW   = (NUM_ANALOG > 1) ? $clog2(NUM_ANALOG) : 1;
   localparam int ADEP  = 2 ** AIW;

   // Fetch stage: the accepted word and the two bytes read for it.
   logic          s1_vld_ff;
   req_type       s1_ff;
   logic [7:0]    rd_a_ff;
   logic [7:0]    rd_b_ff;
   logic          vld_a_ff;
   logic          vld_b_ff;
   logic          fwd_a_ff;
   logic          fwd_b_ff;
   logic [7:0]    fwd_data_ff;

   // Byte store with one valid bit per entry.
   logic [7:0]    store_ff [DEPTH];
   logic          entry_vld_ff [DEPTH];
   logic [9:0]    analog_ff [ADEP];

   // Result register.
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   rsp_type       rsp_ff;

   req_type       req_word;
   rsp_type       exec_rsp;
   upd_type       exec_upd;
   logic          accept;
   logic          advance;
   logic          wr_fire;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr_a;
   logic [AW-1:0] rd_addr_b;
   logic [7:0]    byte_a;
   logic [7:0]    byte_b;
   logic [7:0]    old_byte;
   logic [7:0]    dir_byte;
   logic [9:0]    ana_level;
   logic          is_ext;

   assign req_word = '{op:             req_op,
                       reg_addr:       req_reg_addr,
                       bit_index:      req_bit_index,
                       data_byte:      req_data_byte,
                       port_index:     req_port_index,
                       analog_channel: req_analog_channel,
                       analog_value:   req_analog_value};

   // The fetch stage moves on when the result register is free or draining.
   assign advance   = s1_vld_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_vld_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign wr_fire   = advance && exec_upd.reg_en;
   assign wr_addr   = exec_upd.reg_addr[AW-1:0];

   // Read addresses. A bit read looks at the output bank behind the pin
   // address; outside operations look at the port and its direction bank.
   always_comb begin
      is_ext = (req_op == OP_EXT_WRITE) || (req_op == OP_EXT_SET) ||
               (req_op == OP_EXT_CLEAR);
      if (req_op == OP_CPU_RDBIT) begin
         rd_addr_a = AW'(req_reg_addr - 8'(2 * NUM_PORTS));
      end else if (is_ext) begin
         rd_addr_a = AW'({4'd0, req_port_index});
      end else begin
         rd_addr_a = AW'(req_reg_addr);
      end
      if (is_ext) begin
         rd_addr_b = AW'({4'd0, req_port_index} + 8'(NUM_PORTS));
      end else begin
         rd_addr_b = AW'(req_reg_addr + 8'(NUM_PORTS));
      end
   end

   // Store write and two registered reads.
   always_ff @(posedge clock) begin
      if (wr_fire) begin
         store_ff[wr_addr] <= exec_upd.reg_data;
      end
      if (accept) begin
         rd_a_ff <= store_ff[rd_addr_a];
         rd_b_ff <= store_ff[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            entry_vld_ff[i] <= 1'b0;
         end
      end else if (wr_fire) begin
         entry_vld_ff[wr_addr] <= 1'b1;
      end
   end

   // Valid flags and forwarding of a write that lands on the read edge.
   always_ff @(posedge clock) begin
      if (accept) begin
         vld_a_ff    <= entry_vld_ff[rd_addr_a];
         vld_b_ff    <= entry_vld_ff[rd_addr_b];
         fwd_a_ff    <= wr_fire && (wr_addr == rd_addr_a);
         fwd_b_ff    <= wr_fire && (wr_addr == rd_addr_b);
         fwd_data_ff <= exec_upd.reg_data;
         s1_ff       <= req_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (accept) begin
         s1_vld_ff <= 1'b1;
      end else if (advance) begin
         s1_vld_ff <= 1'b0;
      end
   end

   assign byte_a    = vld_a_ff ? rd_a_ff : 8'd0;
   assign byte_b    = vld_b_ff ? rd_b_ff : 8'd0;
   assign old_byte  = fwd_a_ff ? fwd_data_ff : byte_a;
   assign dir_byte  = fwd_b_ff ? fwd_data_ff : byte_b;
   assign ana_level = analog_ff[s1_ff.analog_channel[AIW-1:0]];

   gpiopr_exec #(
      .NUM_PORTS  (NUM_PORTS),
      .NUM_REGS   (NUM_REGS),
      .NUM_ANALOG (NUM_ANALOG)
   ) u_exec (
      .req       (s1_ff),
      .old_byte  (old_byte),
      .dir_byte  (dir_byte),
      .ana_level (ana_level),
      .rsp       (exec_rsp),
      .upd       (exec_upd)
   );

   // Analog levels are few enough to live in flip-flops.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ADEP; i++) begin
            analog_ff[i] <= 10'd0;
         end
      end else if (advance && exec_upd.ana_en) begin
         analog_ff[exec_upd.ana_channel[AIW-1:0]] <= exec_upd.ana_data;
      end
   end

   // Result register.
   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= exec_rsp;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_ff.read_value;
   assign rsp_event_kind  = rsp_ff.event_kind;
   assign rsp_event_index = rsp_ff.event_index;
   assign rsp_event_value = rsp_ff.event_value;
   assign rsp_warning     = rsp_ff.warning;

endmodule : gpio_port_register_model_unit
`default_nettype wire

// ===== hdl/gpiopr_exec.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO port register execute logic
// Decodes one word against the fetched bytes and produces result and updates.
// ----------------------------------------------------------------------------
module gpiopr_exec #(
   parameter int NUM_PORTS  = 11,
   parameter int NUM_REGS   = 255,
   parameter int NUM_ANALOG = 16
) (
   input  gpiopr_pkg::req_type req,
   input  logic [7:0]          old_byte,   // addressed byte (or pin source byte)
   input  logic [7:0]          dir_byte,   // direction byte of the addressed port
   input  logic [9:0]          ana_level,  // current level of the addressed channel
   output gpiopr_pkg::rsp_type rsp,
   output gpiopr_pkg::upd_type upd
);
   import gpiopr_pkg::*;

   logic [7:0] mask;
   logic [7:0] nv;
   logic [7:0] ext_nv;
   logic       is_port;
   logic       is_ddr;
   logic       is_pin;
   logic       reg_bad;
   logic       port_bad;
   logic       ana_bad;
   logic       blocked;

   always_comb begin
      mask     = 8'b1 << req.bit_index;
      is_port  = req.reg_addr < 8'(NUM_PORTS);
      is_ddr   = !is_port && (req.reg_addr < 8'(2 * NUM_PORTS));
      is_pin   = (req.reg_addr >= 8'(2 * NUM_PORTS)) && (req.reg_addr < 8'(3 * NUM_PORTS));
      reg_bad  = {1'b0, req.reg_addr} >= 9'(NUM_REGS);
      port_bad = {1'b0, req.port_index} >= 5'(NUM_PORTS);
      ana_bad  = {1'b0, req.analog_channel} >= 5'(NUM_ANALOG);

      unique case (req.op)
         OP_CPU_WRITE, OP_EXT_WRITE: nv = req.data_byte;
         OP_CPU_SET, OP_EXT_SET:     nv = old_byte | mask;
         default:                    nv = old_byte & ~mask;
      endcase
      ext_nv  = nv;
      blocked = (req.op == OP_CPU_WRITE) ? (dir_byte == ALL_ZERO_BYTE)
                                         : ((req.op == OP_CPU_CLEAR) && ((dir_byte & mask) == 8'd0));

      rsp = '0;
      upd = '0;
      upd.reg_addr    = req.reg_addr;
      upd.reg_data    = nv;
      upd.ana_channel = req.analog_channel;
      upd.ana_data    = req.analog_value;

      unique case (req.op)
         OP_CPU_WRITE, OP_CPU_SET, OP_CPU_CLEAR: begin
            if (reg_bad) begin
               rsp.warning = WARN_BAD_ADDR;
            end else if (is_port) begin
               if (old_byte != nv) begin
                  if (blocked) begin
                     rsp.warning = WARN_BLOCKED;
                  end else begin
                     upd.reg_en      = 1'b1;
                     rsp.event_kind  = EV_PORT;
                     rsp.event_index = req.reg_addr[3:0];
                     rsp.event_value = {2'b00, nv};
                  end
               end
            end else if (is_ddr) begin
               if (old_byte != nv) begin
                  upd.reg_en      = 1'b1;
                  rsp.event_kind  = EV_DIR;
                  rsp.event_index = 4'(req.reg_addr - 8'(NUM_PORTS));
                  rsp.event_value = {2'b00, nv};
               end
            end else if ((req.op == OP_CPU_WRITE) && (req.reg_addr == SERIAL_DATA_ADDR)) begin
               upd.reg_en      = 1'b1;
               rsp.event_kind  = EV_PORT;
               rsp.event_index = SERIAL_ECHO_PORT;
               rsp.event_value = {2'b00, nv};
            end else if ((req.op == OP_CPU_SET) && is_pin) begin
               rsp.warning = WARN_PIN_WRITE;
            end else begin
               upd.reg_en = 1'b1;
            end
         end
         OP_CPU_READ: begin
            if (reg_bad) begin
               rsp.warning = WARN_BAD_ADDR;
            end else begin
               rsp.read_value = {2'b00, old_byte};
            end
         end
         OP_CPU_RDBIT: begin
            if (req.reg_addr == STATUS_ADDR) begin
               rsp.read_value = 10'd1;
            end else if (reg_bad || (req.reg_addr < 8'(2 * NUM_PORTS))) begin
               rsp.warning = WARN_BAD_ADDR;
            end else begin
               rsp.read_value = {9'd0, |(old_byte & mask)};
            end
         end
         OP_EXT_WRITE, OP_EXT_SET, OP_EXT_CLEAR: begin
            if (port_bad) begin
               rsp.warning = WARN_BAD_ADDR;
            end else begin
               if (req.op == OP_EXT_WRITE) begin
                  if ((req.data_byte & ~dir_byte) != ALL_ONES_BYTE) begin
                     rsp.warning = WARN_EXT_DIR;
                  end
               end else if ((dir_byte & mask) != 8'd0) begin
                  rsp.warning = WARN_EXT_DIR;
               end
               upd.reg_addr = {4'd0, req.port_index};
               if (old_byte != ext_nv) begin
                  upd.reg_en      = 1'b1;
                  rsp.event_kind  = EV_PORT;
                  rsp.event_index = req.port_index;
                  rsp.event_value = {2'b00, ext_nv};
               end
            end
         end
         OP_ANA_SET: begin
            if (ana_bad) begin
               rsp.warning = WARN_BAD_ADDR;
            end else if (ana_level != req.analog_value) begin
               upd.ana_en      = 1'b1;
               rsp.event_kind  = EV_ANALOG;
               rsp.event_index = req.analog_channel;
               rsp.event_value = req.analog_value;
            end
         end
         OP_ANA_READ: begin
            if (ana_bad) begin
               rsp.warning = WARN_BAD_ADDR;
            end else begin
               rsp.read_value = ana_level;
            end
         end
         default: begin
            rsp = '0;
         end
      endcase
   end

endmodule : gpiopr_exec
`default_nettype wire

// ===== sim/tb_gpio_port_register_model_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO port register model unit testbench
// Drives CPU, outside-component and analog words through the request channel
// and checks every result word against a typed result or a behavioral mirror of the
// register file, with bursty sending and a receiver that stalls on its own schedule.
// ----------------------------------------------------------------------------
module tb_gpio_port_register_model_unit;
   import gpiopr_pkg::*;

   localparam int NUM_PORTS      = 11;
   localparam int NUM_REGS       = 255;
   localparam int NUM_ANALOG     = 16;
   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 10;
   localparam int RANDOM_WORDS   = 750;
   localparam int LONG_HOLD      = 80;     // one long receiver hold-off, in cycles
   localparam int HOLD_AFTER     = 200;    // words accepted before that hold-off
   localparam int DRAIN_CYCLES   = 8;      // two-stage pipe plus margin
   localparam int WATCHDOG_LIMIT = 1000;   // cycles without any handshake
   localparam int REPORT_LIMIT   = 10;

   // Opcodes 10 to 15 are unused: the block must answer them with all zeros.
   localparam logic [3:0] OP_UNUSED_LO = 4'd10;
   localparam logic [3:0] OP_UNUSED_HI = 4'd15;

   // One row of the directed plan. When has_want is set the expected result is
   // the typed-in one; otherwise the mirror decides it.
   typedef struct packed {
      req_type w;
      logic    has_want;
      rsp_type want;
   } plan_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [3:0] req_op = '0;
   logic [7:0] req_reg_addr = '0;
   logic [2:0] req_bit_index = '0;
   logic [7:0] req_data_byte = '0;
   logic [3:0] req_port_index = '0;
   logic [3:0] req_analog_channel = '0;
   logic [9:0] req_analog_value = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [9:0] rsp_read_value;
   logic [1:0] rsp_event_kind;
   logic [3:0] rsp_event_index;
   logic [9:0] rsp_event_value;
   logic [2:0] rsp_warning;

   // Typed expectation that travels with the word currently on offer.
   logic    offer_has_want = 1'b0;
   rsp_type offer_want = '0;

   // Mirror of the byte store and the analog levels, updated per accepted word.
   logic [7:0] reg_mirror [0:255];
   logic [9:0] level_mirror [0:15];

   rsp_type      outcome_q [$];      // results still owed by the block, oldest first
   plan_row_type directed_plan [$];
   int           words_taken = 0;
   int           error_count = 0;
   int           quiet_cycles = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   gpio_port_register_model_unit #(
      .NUM_PORTS  (NUM_PORTS),
      .NUM_REGS   (NUM_REGS),
      .NUM_ANALOG (NUM_ANALOG)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_reg_addr       (req_reg_addr),
      .req_bit_index      (req_bit_index),
      .req_data_byte      (req_data_byte),
      .req_port_index     (req_port_index),
      .req_analog_channel (req_analog_channel),
      .req_analog_value   (req_analog_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_value     (rsp_read_value),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_event_index    (rsp_event_index),
      .rsp_event_value    (rsp_event_value),
      .rsp_warning        (rsp_warning)
   );

   // Applies one word to the mirror and returns the result word it must give.
   // The address checks run in the order port, direction, serial data or pin,
   // then general storage, so overlapping rules resolve the same way as in the
   // block.
   function automatic rsp_type port_file_outcome(req_type w);
      rsp_type    r;
      logic [7:0] addr;
      logic [7:0] mask;
      logic [7:0] old;
      logic [7:0] nv;
      logic [7:0] dir;
      logic [7:0] pin_byte;
      r    = '0;
      addr = w.reg_addr;
      mask = 8'd1 << w.bit_index;
      case (w.op)
         OP_CPU_WRITE, OP_CPU_SET, OP_CPU_CLEAR, OP_CPU_READ: begin
            if (addr >= NUM_REGS) begin
               r.warning = WARN_BAD_ADDR;
            end else if (w.op == OP_CPU_READ) begin
               r.read_value = {2'b00, reg_mirror[addr]};
            end else begin
               old = reg_mirror[addr];
               if (w.op == OP_CPU_WRITE) nv = w.data_byte;
               else if (w.op == OP_CPU_SET) nv = old | mask;
               else nv = old & ~mask;
               if (addr < NUM_PORTS) begin
                  // A port changes only when the value moves; a byte write needs
                  // some output bit, a clear needs that bit's direction set.
                  if (old != nv) begin
                     dir = reg_mirror[addr + NUM_PORTS];
                     if ((w.op == OP_CPU_WRITE && dir == ALL_ZERO_BYTE) ||
                         (w.op == OP_CPU_CLEAR && (dir & mask) == ALL_ZERO_BYTE)) begin
                        r.warning = WARN_BLOCKED;
                     end else begin
                        reg_mirror[addr] = nv;
                        r.event_kind  = EV_PORT;
                        r.event_index = addr[3:0];
                        r.event_value = {2'b00, nv};
                     end
                  end
               end else if (addr < 2 * NUM_PORTS) begin
                  if (old != nv) begin
                     reg_mirror[addr] = nv;
                     r.event_kind  = EV_DIR;
                     r.event_index = 4'(addr - NUM_PORTS);
                     r.event_value = {2'b00, nv};
                  end
               end else if (w.op == OP_CPU_WRITE && addr == SERIAL_DATA_ADDR) begin
                  // The serial data register always echoes, even with no change.
                  reg_mirror[addr] = nv;
                  r.event_kind  = EV_PORT;
                  r.event_index = SERIAL_ECHO_PORT;
                  r.event_value = {2'b00, nv};
               end else if (w.op == OP_CPU_SET && addr < 3 * NUM_PORTS) begin
                  r.warning = WARN_PIN_WRITE;
               end else begin
                  reg_mirror[addr] = nv;
               end
            end
         end
         OP_CPU_RDBIT: begin
            if (addr == STATUS_ADDR) begin
               r.read_value = 10'd1;
            end else if (addr >= NUM_REGS || addr < 2 * NUM_PORTS) begin
               r.warning = WARN_BAD_ADDR;
            end else begin
               // Pin addresses read back the output register of the same bank.
               pin_byte = reg_mirror[addr - 2 * NUM_PORTS];
               r.read_value = {9'd0, pin_byte[w.bit_index]};
            end
         end
         OP_EXT_WRITE, OP_EXT_SET, OP_EXT_CLEAR: begin
            if (w.port_index >= NUM_PORTS) begin
               r.warning = WARN_BAD_ADDR;
            end else begin
               dir = reg_mirror[w.port_index + NUM_PORTS];
               old = reg_mirror[w.port_index];
               if (w.op == OP_EXT_WRITE) begin
                  // Only all ones onto a fully input port is free of conflict.
                  if ((w.data_byte & ~dir) != ALL_ONES_BYTE) r.warning = WARN_EXT_DIR;
                  nv = w.data_byte;
               end else begin
                  if ((dir & mask) != ALL_ZERO_BYTE) r.warning = WARN_EXT_DIR;
                  nv = (w.op == OP_EXT_SET) ? (old | mask) : (old & ~mask);
               end
               if (old != nv) begin
                  reg_mirror[w.port_index] = nv;
                  r.event_kind  = EV_PORT;
                  r.event_index = w.port_index;
                  r.event_value = {2'b00, nv};
               end
            end
         end
         OP_ANA_SET: begin
            if (w.analog_channel >= NUM_ANALOG) begin
               r.warning = WARN_BAD_ADDR;
            end else if (level_mirror[w.analog_channel] != w.analog_value) begin
               level_mirror[w.analog_channel] = w.analog_value;
               r.event_kind  = EV_ANALOG;
               r.event_index = w.analog_channel;
               r.event_value = w.analog_value;
            end
         end
         OP_ANA_READ: begin
            if (w.analog_channel >= NUM_ANALOG) r.warning = WARN_BAD_ADDR;
            else r.read_value = level_mirror[w.analog_channel];
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // Directed plan rows: one checked by the mirror, one with a typed result.
   function automatic void step(logic [3:0] op, logic [7:0] addr, logic [2:0] bitn,
                                logic [7:0] data, logic [3:0] port, logic [3:0] ch,
                                logic [9:0] level);
      plan_row_type p;
      p = '0;
      p.w = '{op, addr, bitn, data, port, ch, level};
      directed_plan.push_back(p);
   endfunction

   function automatic void step_is(logic [3:0] op, logic [7:0] addr, logic [2:0] bitn,
                                   logic [7:0] data, logic [3:0] port, logic [3:0] ch,
                                   logic [9:0] level, logic [9:0] rd, logic [1:0] kind,
                                   logic [3:0] idx, logic [9:0] val, logic [2:0] warn);
      plan_row_type p;
      p.w        = '{op, addr, bitn, data, port, ch, level};
      p.has_want = 1'b1;
      p.want     = '{rd, kind, idx, val, warn};
      directed_plan.push_back(p);
   endfunction

   // Random word. Every field but the opcode starts fully random so that all bits
   // toggle; then addresses are pulled toward the port, direction and pin banks, and
   // data toward the values that hit the no-change and no-conflict cases.
   function automatic req_type random_word();
      req_type w;
      int      pick;
      w.op             = 4'($urandom_range(0, 9));
      w.reg_addr       = 8'($urandom);
      w.bit_index      = 3'($urandom);
      w.data_byte      = 8'($urandom);
      w.port_index     = 4'($urandom);
      w.analog_channel = 4'($urandom);
      w.analog_value   = 10'($urandom);
      if ($urandom_range(0, 15) == 0) w.op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      pick = $urandom_range(0, 9);
      if (pick < 7) w.reg_addr = 8'($urandom_range(0, 3 * NUM_PORTS + 4));
      else if (pick == 7) w.reg_addr = ($urandom_range(0, 1) == 1) ? STATUS_ADDR
                                                                     : SERIAL_DATA_ADDR;
      if ($urandom_range(0, 5) != 0) w.port_index = 4'($urandom_range(0, NUM_PORTS - 1));
      case ($urandom_range(0, 7))
         0: w.data_byte = ALL_ONES_BYTE;
         1: w.data_byte = ALL_ZERO_BYTE;
         2: w.data_byte = (w.op >= OP_EXT_WRITE) ? reg_mirror[w.port_index]
                                                 : reg_mirror[w.reg_addr];
         default: begin
         end
      endcase
      case ($urandom_range(0, 5))
         0: w.analog_value = 10'd0;
         1: w.analog_value = 10'h3FF;
         2: w.analog_value = level_mirror[w.analog_channel];
         default: begin
         end
      endcase
      return w;
   endfunction

   // Puts one word on the request channel at the falling edge and holds it
   // until the block takes it. Valid stays high across back-to-back words.
   task automatic offer(input req_type w, input logic has_want, input rsp_type want);
      @(negedge clock);
      req_valid          <= 1'b1;
      req_op             <= w.op;
      req_reg_addr       <= w.reg_addr;
      req_bit_index      <= w.bit_index;
      req_data_byte      <= w.data_byte;
      req_port_index     <= w.port_index;
      req_analog_channel <= w.analog_channel;
      req_analog_value   <= w.analog_value;
      offer_has_want     <= has_want;
      offer_want         <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Lowers valid and waits until the block owes nothing.
   task automatic pause_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outcome_q.size() != 0) @(negedge clock);
   endtask

   task automatic report_mismatch(input string what, input rsp_type want,
                                  input rsp_type got);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("%0t %s: expected rd=%0d ev=%0d/%0d/%0d warn=%0d, got rd=%0d ev=%0d/%0d/%0d warn=%0d",
                  $realtime, what, want.read_value, want.event_kind, want.event_index,
                  want.event_value, want.warning, got.read_value, got.event_kind,
                  got.event_index, got.event_value, got.warning);
   endtask

   // Both channels are sampled at the rising edge, before the block's own
   // registers update. The result side is handled first so that a word taken
   // on the same edge can never be matched against its own result.
   always @(posedge clock) begin : channel_monitor
      req_type w;
      rsp_type got;
      rsp_type want;
      rsp_type predicted;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_read_value, rsp_event_kind, rsp_event_index, rsp_event_value,
                    rsp_warning};
            if (outcome_q.size() == 0) begin
               report_mismatch("result word with none outstanding", '0, got);
            end else begin
               want = outcome_q.pop_front();
               if (got.read_value  !== want.read_value  || got.event_kind  !== want.event_kind ||
                   got.event_index !== want.event_index || got.event_value !== want.event_value ||
                   got.warning     !== want.warning)
                  report_mismatch("result word mismatch", want, got);
            end
         end
         if (req_valid && !req_stall) begin
            w = '{req_op, req_reg_addr, req_bit_index, req_data_byte, req_port_index,
                  req_analog_channel, req_analog_value};
            // The mirror sees every word, typed rows included, so it never
            // falls out of step with the block.
            predicted = port_file_outcome(w);
            outcome_q.push_back(offer_has_want ? offer_want : predicted);
            words_taken++;
         end
         // Watchdog: a run in which no word moves on either side for too long
         // is a hang.
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Receiver. It runs spans of no stall, light stall, heavy stall and a
   // toggling pattern, and once, after enough traffic, a long hold-off during
   // which the sender keeps offering so that the pipe fills and req_stall rises.
   initial begin : receiver
      int mode;
      int span;
      bit held_long;
      held_long = 1'b0;
      wait (!reset);
      forever begin
         if (!held_long && words_taken >= HOLD_AFTER) begin
            held_long = 1'b1;
            repeat (LONG_HOLD) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 60);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   // Sender: the directed plan, a full drain, then random words in bursts.
   initial begin : sender
      int sent;
      int burst;
      int gap;
      bit drained_midway;
      foreach (reg_mirror[i]) reg_mirror[i] = '0;
      foreach (level_mirror[i]) level_mirror[i] = '0;

      // Directed plan. Port 0 gets its direction byte set and cleared so that
      // the blocked write and blocked clear cases both appear; port 1 takes the
      // outside-component rules.
      step_is(OP_CPU_READ,  8'd0,   3'd0, 8'h00, 4'd0,  4'd0,  10'd0,
              10'd0, EV_NONE, 4'd0, 10'd0, WARN_NONE);
      step_is(OP_ANA_READ,  8'd0,   3'd0, 8'h00, 4'd0,  4'd15, 10'd0,
              10'd0, EV_NONE, 4'd0, 10'd0, WARN_NONE);
      step_is(OP_CPU_WRITE, 8'd0,   3'd0, 8'hFF, 4'd0,  4'd0,  10'd0,
              10'd0, EV_NONE, 4'd0, 10'd0, WARN_BLOCKED);
      step_is(OP_CPU_WRITE, 8'd11,  3'd0, 8'hFF, 4'd0,  4'd0,  10'd0,
              10'd0, EV_DIR, 4'd0, 10'h0FF, WARN_NONE);
      step(OP_CPU_WRITE, 8'd0,  3'd0, 8'hA5, 4'd0, 4'd0, 10'd0);
      step(OP_CPU_CLEAR, 8'd0,  3'd7, 8'h00, 4'd0, 4'd0, 10'd0);
      step(OP_CPU_WRITE, 8'd11, 3'd0, 8'h00, 4'd0, 4'd0, 10'd0);
      step(OP_CPU_CLEAR, 8'd0,  3'd0, 8'h00, 4'd0, 4'd0, 10'd0);
      step(OP_CPU_SET,   8'd10, 3'd3, 8'h00, 4'd0, 4'd0, 10'd0);
      step_is(OP_CPU_SET,   8'd22,  3'd2, 8'h00, 4'd0,  4'd0,  10'd0,
              10'd0, EV_NONE, 4'd0, 10'd0, WARN_PIN_WRITE);
      step_is(OP_CPU_WRITE, SERIAL_DATA_ADDR, 3'd0, 8'h5A, 4'd0, 4'd0, 10'd0,
              10'd0, EV_PORT, SERIAL_ECHO_PORT, 10'h05A, WARN_NONE);
      step_is(OP_CPU_RDBIT, STATUS_ADDR, 3'd7, 8'h00, 4'd0, 4'd0, 10'd0,
              10'd1, EV_NONE, 4'd0, 10'd0, WARN_NONE);
      step_is(OP_CPU_RDBIT, 8'd21,  3'd0, 8'h00, 4'd0,  4'd0,  10'd0,
              10'd0, EV_NONE, 4'd0, 10'd0, WARN_BAD_ADDR);
      step(OP_CPU_RDBIT, 8'd22, 3'd0, 8'h00, 4'd0, 4'd0, 10'd0);
      step_is(OP_CPU_WRITE, 8'd255, 3'd0, 8'hFF, 4'd0,  4'd0,  10'd0,
              10'd0, EV_NONE, 4'd0, 10'd0, WARN_BAD_ADDR);
      step_is(OP_EXT_WRITE, 8'd0,   3'd0, 8'hFF, 4'd1,  4'd0,  10'd0,
              10'd0, EV_PORT, 4'd1, 10'h0FF, WARN_NONE);
      step(OP_EXT_WRITE, 8'd0,  3'd0, 8'h00, 4'd1, 4'd0, 10'd0);
      step(OP_CPU_WRITE, 8'd12, 3'd0, 8'h0F, 4'd0, 4'd0, 10'd0);
      step(OP_EXT_SET,   8'd0,  3'd0, 8'h00, 4'd1, 4'd0, 10'd0);
      step(OP_EXT_CLEAR, 8'd0,  3'd7, 8'h00, 4'd1, 4'd0, 10'd0);
      step_is(OP_EXT_SET,   8'd0,   3'd0, 8'h00, 4'd15, 4'd0,  10'd0,
              10'd0, EV_NONE, 4'd0, 10'd0, WARN_BAD_ADDR);
      step_is(OP_ANA_SET,   8'd0,   3'd0, 8'h00, 4'd0,  4'd15, 10'h3FF,
              10'd0, EV_ANALOG, 4'd15, 10'h3FF, WARN_NONE);
      step(OP_ANA_READ,  8'd0,  3'd0, 8'h00, 4'd0, 4'd15, 10'd0);
      step_is(OP_ANA_SET,   8'd0,   3'd0, 8'h00, 4'd0,  4'd0,  10'd0,
              10'd0, EV_NONE, 4'd0, 10'd0, WARN_NONE);
      step_is(OP_UNUSED_HI, 8'hFF,  3'd7, 8'hFF, 4'd15, 4'd15, 10'h3FF,
              10'd0, EV_NONE, 4'd0, 10'd0, WARN_NONE);

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < directed_plan.size(); i++)
         offer(directed_plan[i].w, directed_plan[i].has_want, directed_plan[i].want);
      pause_until_drained();

      // Random part. Roughly a quarter of the bursts follow the previous one
      // with no gap, which gives long stretches of back-to-back words.
      sent = 0;
      drained_midway = 1'b0;
      while (sent < RANDOM_WORDS) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            offer(random_word(), 1'b0, '0);
            sent++;
         end
         if (!drained_midway && sent >= RANDOM_WORDS / 2) begin
            drained_midway = 1'b1;
            pause_until_drained();
         end
      end

      // Let the last results out, then keep watching for strays.
      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && outcome_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
hdl/gpiopr_pkg.sv
hdl/gpiopr_exec.sv
hdl/gpio_port_register_model_unit.sv
sim/tb_gpio_port_register_model_unit.sv
